// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Queue depth, field widths, operation and status codes, cell link types.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int VAL_W  = 32;
	localparam int PRIO_W = 16;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell for one request
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic signed [VAL_W-1:0]  value;
		logic        [PRIO_W-1:0] prio;
	} cmd_t;

	// handed from a cell toward the tail
	typedef struct packed {
		logic                     move;
		logic                     stop;
		logic signed [VAL_W-1:0]  value;
		logic        [PRIO_W-1:0] prio;
	} link_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a sorted shift chain
// Entries are kept in ascending priority order, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one request: func selects
//  insert or delete head; item_value and item_priority are the entry to
//  insert. Output channel (out_valid / out_stall) returns one result per
//  request: status, the removed entry (zero unless a delete succeeded) and
//  entry_count after the step.
//  The result is registered at the edge that accepts the request.
//  Throughput is one request per cycle while the output is not stalled;
//  every cell compares its priority to the new one in parallel and shifts
//  in the same cycle, so the cell chain is what sets that figure.
//  Equal priorities leave in arrival order. Insert into a full queue is
//  dropped with status full; delete of an empty queue reports empty.
//  Reset empties the queue and clears the output valid; cell contents are
//  not cleared, only the count marks which cells hold entries.
//  While the receiver stalls, the held result stays put and in_stall is
//  raised, so no further request is taken until the result leaves.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     func,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic        [PRIO_W-1:0] item_priority,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic        [1:0]        status,
	output logic signed [VAL_W-1:0]  removed_value,
	output logic        [PRIO_W-1:0] removed_priority,
	output logic        [CNT_W-1:0]  entry_count
);

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	cmd_t                     cmd;
	link_t                    chain [DEPTH+1];
	logic signed [VAL_W-1:0]  back_value [DEPTH+1];
	logic        [PRIO_W-1:0] back_prio  [DEPTH+1];

	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [VAL_W-1:0]  rval_q;
	logic        [PRIO_W-1:0] rprio_q;
	logic [CNT_W-1:0]         rcount_q;

	// output register frees as soon as its result is taken
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;

	always_comb begin
		cmd.ins   = accept && (func == FUNC_INSERT) && !full;
		cmd.del   = accept && (func == FUNC_DELETE) && !empty;
		cmd.value = item_value;
		cmd.prio  = item_priority;
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (cmd.del) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// head cell: nothing ahead of it, new entry may land here
	assign chain[0]          = '{move: 1'b0, stop: 1'b1, value: '0, prio: '0};
	assign back_value[DEPTH] = '0;
	assign back_prio[DEPTH]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (count_q > CNT_W'(i)),
			.left        (chain[i]),
			.right_value (back_value[i+1]),
			.right_prio  (back_prio[i+1]),
			.link        (chain[i+1])
		);
		assign back_value[i] = chain[i+1].value;
		assign back_prio[i]  = chain[i+1].prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rcount_q <= count_nxt;
			if (cmd.del) begin
				status_q <= ST_DONE;
				rval_q   <= chain[1].value;
				rprio_q  <= chain[1].prio;
			end else begin
				rval_q  <= '0;
				rprio_q <= '0;
				priority if (func == FUNC_INSERT && full) begin
					status_q <= ST_FULL;
				end else if (func == FUNC_DELETE) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_DONE;
				end
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign removed_value    = rval_q;
	assign removed_priority = rprio_q;
	assign entry_count      = rcount_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_INSERT && full) |=> (count_q == CNT_W'(DEPTH)))
		else $error("insert into full queue changed count");

	a_report_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rcount_q == count_q))
		else $error("reported count differs from stored count");

	a_zero_removed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_DONE) |-> (rval_q == '0 && rprio_q == '0))
		else $error("failed request returned an entry");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> (chain[1].prio <= chain[2].prio))
		else $error("head cells out of order");
`endif

endmodule

// ===== hw/rtl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on insert keeps, takes the new entry or takes its left
// neighbor; on delete takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  cmd_t                     cmd,
	input  logic                     occ,
	input  link_t                    left,
	input  logic signed [VAL_W-1:0]  right_value,
	input  logic        [PRIO_W-1:0] right_prio,
	output link_t                    link
);

	logic signed [VAL_W-1:0]  value_q;
	logic        [PRIO_W-1:0] prio_q;
	logic                     gt;

	// stored entry goes behind the new one only if strictly greater
	assign gt = prio_q > cmd.prio;

	always_comb begin
		link.move  = occ && gt;
		link.stop  = occ && !gt;
		link.value = value_q;
		link.prio  = prio_q;
	end

	always_ff @(posedge clk) begin
		priority if (cmd.del) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end else if (cmd.ins && left.move) begin
			value_q <= left.value;
			prio_q  <= left.prio;
		end else if (cmd.ins && left.stop && (!occ || gt)) begin
			value_q <= cmd.value;
			prio_q  <= cmd.prio;
		end
	end

endmodule
